>>> design/dets_pkg.sv
// Shared types and codes for the deadline event table.
`default_nettype none

package dets_pkg;

    localparam int KEY_W = 56;
    localparam int DUE_W = 32;

    // Command codes carried on s_tuser
    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_POP      = 1'b1;

    // Result status codes carried on m_tuser
    localparam logic [2:0] STS_NEW     = 3'd0;
    localparam logic [2:0] STS_MERGED  = 3'd1;
    localparam logic [2:0] STS_EVICTED = 3'd2;
    localparam logic [2:0] STS_DROPPED = 3'd3;
    localparam logic [2:0] STS_POPPED  = 3'd4;
    localparam logic [2:0] STS_NONE    = 3'd5;

    // One table entry as stored in memory; key is {x, y, z, type}
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [DUE_W-1:0] due;
    } entry_t;

    // What the scan found over the whole table
    typedef struct packed {
        logic match_found;
        logic free_found;
        logic best_found;
    } scan_flags_t;

endpackage

`default_nettype wire

>>> design/dets_scan.sv
// Running search over the table entries streamed out of memory, one per cycle.
`default_nettype none

module dets_scan #(
    parameter int IDX_W = 6
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic                      ent_vld,
    input  wire logic [IDX_W-1:0]          ent_idx,
    input  wire dets_pkg::entry_t          ent,
    input  wire logic [dets_pkg::KEY_W-1:0] key,
    input  wire logic [dets_pkg::DUE_W-1:0] now,
    output dets_pkg::scan_flags_t          flags,
    output logic [IDX_W-1:0]               match_idx,
    output logic [dets_pkg::DUE_W-1:0]     match_due,
    output logic [IDX_W-1:0]               free_idx,
    output logic [IDX_W-1:0]               worst_idx,
    output logic [dets_pkg::DUE_W-1:0]     worst_due,
    output logic [IDX_W-1:0]               best_idx,
    output logic [dets_pkg::KEY_W-1:0]     best_key,
    output logic [dets_pkg::DUE_W-1:0]     best_due
);
    import dets_pkg::*;

    scan_flags_t      flags_reg;
    logic             worst_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [DUE_W-1:0] match_due_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] worst_idx_reg;
    logic [DUE_W-1:0] worst_due_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [KEY_W-1:0] best_key_reg;
    logic [DUE_W-1:0] best_due_reg;

    logic hit_match;
    logic hit_free;
    logic hit_worst;
    logic hit_best;

    // First match and first free slot win; strict compares keep the lowest index on ties
    always_comb begin
        hit_match = ent_vld && ent.valid && (ent.key == key) && !flags_reg.match_found;
        hit_free  = ent_vld && !ent.valid && !flags_reg.free_found;
        hit_worst = ent_vld && (!worst_found_reg || (ent.due > worst_due_reg));
        hit_best  = ent_vld && ent.valid && (ent.due <= now) &&
                    (!flags_reg.best_found || (ent.due < best_due_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg       <= '0;
            worst_found_reg <= 1'b0;
        end else if (start) begin
            flags_reg       <= '0;
            worst_found_reg <= 1'b0;
        end else begin
            if (hit_match) flags_reg.match_found <= 1'b1;
            if (hit_free)  flags_reg.free_found  <= 1'b1;
            if (hit_best)  flags_reg.best_found  <= 1'b1;
            if (hit_worst) worst_found_reg       <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (hit_match) begin
            match_idx_reg <= ent_idx;
            match_due_reg <= ent.due;
        end
        if (hit_free) begin
            free_idx_reg <= ent_idx;
        end
        if (hit_worst) begin
            worst_idx_reg <= ent_idx;
            worst_due_reg <= ent.due;
        end
        if (hit_best) begin
            best_idx_reg <= ent_idx;
            best_key_reg <= ent.key;
            best_due_reg <= ent.due;
        end
    end

    assign flags     = flags_reg;
    assign match_idx = match_idx_reg;
    assign match_due = match_due_reg;
    assign free_idx  = free_idx_reg;
    assign worst_idx = worst_idx_reg;
    assign worst_due = worst_due_reg;
    assign best_idx  = best_idx_reg;
    assign best_key  = best_key_reg;
    assign best_due  = best_due_reg;

endmodule

`default_nettype wire

>>> design/deadline_event_table_core.sv
// Top level of the deadline event table: entry memory, command sequencer and result register.
// Each item goes through accept, TABLE_DEPTH reads of the single memory read port, a wait for
// the last read to land, and commit (held while a previous result still waits on a low m_tready).
// One item is in work at a time; the next is taken while the previous result waits on m_.
// After reset a clearing pass writes every entry invalid; s_tready stays low until it ends.
// Control state is cleared by aresetn.
`default_nettype none

module deadline_event_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // s_tdata: pos_x[15:0], pos_y[31:16], pos_z[47:32], type_id[55:48],
    //          delay[71:56], now[103:72]
    input  wire logic [103:0] s_tdata,
    // s_tuser: command[0]
    input  wire logic [0:0]   s_tuser,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // m_tdata: out_x[15:0], out_y[31:16], out_z[47:32], out_type[55:48],
    //          out_due[87:56], live_count[94:88], zero pad[95]
    output logic [95:0]       m_tdata,
    // m_tuser: status[2:0]
    output logic [2:0]        m_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready
);
    import dets_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int LW    = (CNT_W > 7) ? CNT_W : 7;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_WAIT   = 5'b01000,
        S_COMMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Entry memory: one write port, one registered read port
    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;
    logic   rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic [IDX_W-1:0] addr_reg;

    // Captured command
    logic             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [DUE_W-1:0] due_reg;
    logic [DUE_W-1:0] now_reg;
    logic [CNT_W-1:0] live_reg, live_next;

    // Result register
    logic         m_valid_reg;
    logic [95:0]  m_tdata_reg, m_tdata_next;
    logic [2:0]   m_tuser_reg, m_tuser_next;

    logic s_fire;
    logic out_fire;

    logic [15:0]  in_delay;
    logic [15:0]  delay_min1;
    logic [32:0]  due_sum;
    logic [DUE_W-1:0] due_in;
    logic [KEY_W-1:0] key_in;

    scan_flags_t      flags;
    logic [IDX_W-1:0] match_idx;
    logic [DUE_W-1:0] match_due;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] worst_idx;
    logic [DUE_W-1:0] worst_due;
    logic [IDX_W-1:0] best_idx;
    logic [KEY_W-1:0] best_key;
    logic [DUE_W-1:0] best_due;

    logic [LW-1:0] live_wide;
    logic [6:0]    live_out;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_fire = (state_reg == S_COMMIT) && (!m_valid_reg || m_tready);

    // Due tick: now + max(delay, 1), saturated at the top of the time range
    assign in_delay   = s_tdata[71:56];
    assign delay_min1 = (in_delay == 16'd0) ? 16'd1 : in_delay;
    assign due_sum    = {1'b0, s_tdata[103:72]} + 33'(delay_min1);
    assign due_in     = due_sum[32] ? '1 : due_sum[31:0];
    assign key_in     = {s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tdata[55:48]};

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (addr_reg == LAST_IDX) state_next = S_IDLE;
            S_IDLE:   if (s_fire) state_next = S_SCAN;
            S_SCAN:   if (addr_reg == LAST_IDX) state_next = S_WAIT;
            S_WAIT:   state_next = S_COMMIT;
            S_COMMIT: if (out_fire) state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == S_SCAN);
            // Sweep the address through the clearing pass and each scan, park at zero
            if ((state_reg == S_CLEAR) || (state_reg == S_SCAN)) begin
                addr_reg <= (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
            end
        end
    end

    // Capture the command on accept
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg <= s_tuser[0];
            key_reg <= key_in;
            due_reg <= due_in;
            now_reg <= s_tdata[103:72];
        end
    end

    // Entry memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
        rd_idx_reg  <= addr_reg;
    end

    dets_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_fire),
        .ent_vld   (rd_vld_reg),
        .ent_idx   (rd_idx_reg),
        .ent       (rd_data_reg),
        .key       (key_reg),
        .now       (now_reg),
        .flags     (flags),
        .match_idx (match_idx),
        .match_due (match_due),
        .free_idx  (free_idx),
        .worst_idx (worst_idx),
        .worst_due (worst_due),
        .best_idx  (best_idx),
        .best_key  (best_key),
        .best_due  (best_due)
    );

    // Clearing writes, and at commit: decide from the scan, write back at most one entry, build the result
    always_comb begin
        wr_en        = 1'b0;
        wr_addr      = addr_reg;
        wr_data      = '0;
        live_next    = live_reg;
        m_tuser_next = STS_NONE;
        m_tdata_next = '0;

        if (state_reg == S_CLEAR) begin
            // Wipe valid bits one entry a cycle
            wr_en = 1'b1;
        end else if (out_fire) begin
            if (cmd_reg == CMD_SCHEDULE) begin
                if (flags.match_found) begin
                    // Same key already live: keep the earlier due tick
                    m_tuser_next = STS_MERGED;
                    wr_en        = (due_reg < match_due);
                    wr_addr      = match_idx;
                    wr_data      = '{valid: 1'b1, key: key_reg, due: due_reg};
                end else if (flags.free_found) begin
                    m_tuser_next = STS_NEW;
                    wr_en        = 1'b1;
                    wr_addr      = free_idx;
                    wr_data      = '{valid: 1'b1, key: key_reg, due: due_reg};
                    live_next    = live_reg + 1'b1;
                end else if (due_reg < worst_due) begin
                    // Full: replace the latest-due entry
                    m_tuser_next = STS_EVICTED;
                    wr_en        = 1'b1;
                    wr_addr      = worst_idx;
                    wr_data      = '{valid: 1'b1, key: key_reg, due: due_reg};
                end else begin
                    m_tuser_next = STS_DROPPED;
                end
            end else begin
                if (flags.best_found) begin
                    // Remove the earliest due entry and hand it out
                    m_tuser_next        = STS_POPPED;
                    wr_en               = 1'b1;
                    wr_addr             = best_idx;
                    wr_data             = '{valid: 1'b0, key: best_key, due: best_due};
                    live_next           = (live_reg != '0) ? live_reg - 1'b1 : live_reg;
                    m_tdata_next[15:0]  = best_key[55:40];
                    m_tdata_next[31:16] = best_key[39:24];
                    m_tdata_next[47:32] = best_key[23:8];
                    m_tdata_next[55:48] = best_key[7:0];
                    m_tdata_next[87:56] = best_due;
                end else begin
                    m_tuser_next = STS_NONE;
                end
            end
        end

        // Report the count saturated to seven bits
        live_wide = LW'(live_next);
        live_out  = (live_wide > LW'(127)) ? 7'd127 : live_wide[6:0];
        m_tdata_next[94:88] = live_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            live_reg <= live_next;
            if (out_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_fire) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
